// ===== rtl/assert_macros.svh =====
// Assertion macros for the module that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check that is suspended while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/nrmc_pkg.sv =====
// Package with the constants, types and helper functions of the RMC field extractor.
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam int MAX_FIELD_LEN = 12;
  localparam int FIELD_LIMIT   = 12;
  localparam int KEPT_FIELDS   = 5;
  localparam int STORE_DEPTH   = KEPT_FIELDS * MAX_FIELD_LEN;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int LEN_W         = $clog2(MAX_FIELD_LEN + 1);
  localparam int FN_W          = 4;
  localparam int SLOT_W        = $clog2(KEPT_FIELDS);
  localparam int POS_W         = 4;
  localparam int INVALID_LEN   = 8;
  localparam int VLEN_W        = 4;

  typedef logic [7:0] byte_t;

  localparam byte_t CH_DOLLAR = 8'h24;
  localparam byte_t CH_STAR   = 8'h2A;
  localparam byte_t CH_COMMA  = 8'h2C;
  localparam byte_t CH_A      = 8'h41;
  localparam byte_t CH_SEMI   = 8'h3B;

  localparam logic [FN_W-1:0] FN_VALIDITY = 4'd2;
  localparam logic [FN_W-1:0] FN_LAST     = FN_W'(FIELD_LIMIT - 1);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_sel_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  function automatic slot_sel_t slot_of(input logic [FN_W-1:0] fn);
    slot_sel_t sel;
    sel.hit  = 1'b1;
    sel.slot = '0;
    unique case (fn)
      4'd1:    sel.slot = SLOT_W'(0);
      4'd3:    sel.slot = SLOT_W'(1);
      4'd4:    sel.slot = SLOT_W'(2);
      4'd5:    sel.slot = SLOT_W'(3);
      4'd6:    sel.slot = SLOT_W'(4);
      default: sel.hit  = 1'b0;
    endcase
    return sel;
  endfunction

  function automatic byte_t invalid_char(input logic [2:0] idx);
    byte_t c;
    unique case (idx)
      3'd0:    c = 8'h49;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h76;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h69;
      3'd6:    c = 8'h64;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                   input logic [POS_W-1:0] pos);
    return ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_FIELD_LEN) + ADDR_W'(pos));
  endfunction

endpackage

// ===== rtl/nrmc_in_if.sv =====
// Interface of the received byte channel.
`timescale 1ns / 1ps

interface nrmc_in_if;
  import nrmc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/nrmc_out_if.sv =====
// Interface of the formatted output byte channel.
`timescale 1ns / 1ps

interface nrmc_out_if;
  import nrmc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  fix_valid;
  logic  last_of_run;

  modport source (output valid, output out_byte, output fix_valid, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input fix_valid, input last_of_run,
                output ready);
endinterface

// ===== rtl/nmea_rmc_field_extractor.sv =====
// Top level of the RMC field extractor: sentence parser, field RAM and run emitter.
//
// The rx channel takes one received character per transaction. Ordinary
// characters are taken in a single cycle each; rx.ready is high whenever the
// block is not fetching a run. A '*' inside a sentence starts a run on the tx
// channel: either the time, latitude, direction, longitude and direction
// fields joined by ';' (fix_valid high) or the text "Invalid" and a newline
// (fix_valid low), with last_of_run marking the final character.
// The run is read out of the field RAM, whose registered read is covered by
// a prefetch stage. A run holds up to 64 characters; after the first they
// follow one per cycle while the receiver is ready. rx.ready stays low until
// the last character has been issued to the prefetch stage.
// When the receiver stalls, the output register and the prefetch stage hold
// and fetching pauses; nothing is lost. Synchronous reset puts the block
// outside a sentence with all field lengths at zero; the field RAM needs no
// clearing since only bytes written in the current sentence are read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nmea_rmc_field_extractor (
  input logic clk,
  input logic rst,
  nrmc_in_if.sink    rx,
  nrmc_out_if.source tx
);
  import nrmc_pkg::*;

  state_t             state;
  logic               capturing;
  logic [FN_W-1:0]    field_number;
  logic [LEN_W-1:0]   field_lengths [KEPT_FIELDS];
  logic [VLEN_W-1:0]  validity_length;
  logic               validity_is_a;

  logic               run_valid;
  logic               phase_sep;
  logic [SLOT_W-1:0]  cur_slot;
  logic [POS_W-1:0]   cur_pos;

  logic               p_valid;
  logic               p_from_mem;
  byte_t              p_char;
  logic               p_last;
  logic               p_fix;

  logic               out_valid;
  byte_t              out_byte;
  logic               out_fix;
  logic               out_last;

  logic               rx_fire;
  slot_sel_t          parse_sel;
  logic [SLOT_W-1:0]  len_idx;
  logic [LEN_W-1:0]   len_cur;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_wr_addr;
  logic               ram_rd_en;
  logic [ADDR_W-1:0]  ram_rd_addr;
  byte_t              ram_rd_data;

  logic               p_moves;
  logic               issue;
  logic               item;
  logic               item_mem;
  byte_t              item_char;
  logic               item_last;
  logic               run_done;
  logic               phase_sep_next;
  logic [SLOT_W-1:0]  cur_slot_next;
  logic [POS_W-1:0]   cur_pos_next;

  assign rx.ready       = (state == S_IDLE);
  assign rx_fire        = rx.valid && rx.ready;
  assign tx.valid       = out_valid;
  assign tx.out_byte    = out_byte;
  assign tx.fix_valid   = out_fix;
  assign tx.last_of_run = out_last;

  assign parse_sel = slot_of(field_number);
  assign len_idx   = (state == S_EMIT) ? cur_slot : parse_sel.slot;
  assign len_cur   = field_lengths[len_idx];

  assign ram_we = rx_fire && capturing && (rx.rx_byte != CH_DOLLAR)
                  && (rx.rx_byte != CH_STAR)
                  && !((rx.rx_byte == CH_COMMA) && (field_number < FN_LAST))
                  && (field_number != FN_VALIDITY) && parse_sel.hit
                  && (len_cur < LEN_W'(MAX_FIELD_LEN));
  assign ram_wr_addr = store_addr(parse_sel.slot, POS_W'(len_cur));

  assign p_moves     = p_valid && (!out_valid || tx.ready);
  assign issue       = (state == S_EMIT) && (!p_valid || p_moves);
  assign ram_rd_en   = issue && item_mem;
  assign ram_rd_addr = store_addr(cur_slot, cur_pos);

  nrmc_field_ram #(
    .DEPTH(STORE_DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (rx.rx_byte),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    item           = 1'b0;
    item_mem       = 1'b0;
    item_char      = CH_SEMI;
    item_last      = 1'b0;
    run_done       = 1'b0;
    phase_sep_next = phase_sep;
    cur_slot_next  = cur_slot;
    cur_pos_next   = cur_pos;
    if (run_valid) begin
      if (phase_sep) begin
        item      = 1'b1;
        item_last = (cur_slot == SLOT_W'(KEPT_FIELDS - 1)) && (len_cur == '0);
        if (len_cur == '0) begin
          if (cur_slot == SLOT_W'(KEPT_FIELDS - 1)) begin
            run_done = 1'b1;
          end else begin
            cur_slot_next = cur_slot + SLOT_W'(1);
          end
        end else begin
          phase_sep_next = 1'b0;
          cur_pos_next   = '0;
        end
      end else if (len_cur == '0) begin
        cur_slot_next  = cur_slot + SLOT_W'(1);
        phase_sep_next = 1'b1;
      end else begin
        item      = 1'b1;
        item_mem  = 1'b1;
        item_last = (cur_slot == SLOT_W'(KEPT_FIELDS - 1))
                    && (cur_pos == POS_W'(len_cur - LEN_W'(1)));
        if (cur_pos == POS_W'(len_cur - LEN_W'(1))) begin
          if (cur_slot == SLOT_W'(KEPT_FIELDS - 1)) begin
            run_done = 1'b1;
          end else begin
            cur_slot_next  = cur_slot + SLOT_W'(1);
            phase_sep_next = 1'b1;
          end
        end else begin
          cur_pos_next = cur_pos + POS_W'(1);
        end
      end
    end else begin
      item         = 1'b1;
      item_char    = invalid_char(cur_pos[2:0]);
      item_last    = (cur_pos == POS_W'(INVALID_LEN - 1));
      run_done     = item_last;
      cur_pos_next = cur_pos + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (p_moves) begin
      out_byte <= p_from_mem ? ram_rd_data : p_char;
      out_fix  <= p_fix;
      out_last <= p_last;
    end
    if (issue && item) begin
      p_from_mem <= item_mem;
      p_char     <= item_char;
      p_last     <= item_last;
      p_fix      <= run_valid;
    end
    if (issue) begin
      phase_sep <= phase_sep_next;
      cur_slot  <= cur_slot_next;
      cur_pos   <= cur_pos_next;
    end
    if (rx_fire && capturing && (rx.rx_byte == CH_STAR)) begin
      run_valid <= validity_is_a && (validity_length == VLEN_W'(1));
      phase_sep <= 1'b0;
      cur_slot  <= '0;
      cur_pos   <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      capturing       <= 1'b0;
      field_number    <= '0;
      validity_length <= '0;
      validity_is_a   <= 1'b0;
      p_valid         <= 1'b0;
      out_valid       <= 1'b0;
      for (int i = 0; i < KEPT_FIELDS; i++) begin
        field_lengths[i] <= '0;
      end
    end else begin
      if (p_moves) begin
        out_valid <= 1'b1;
      end else if (out_valid && tx.ready) begin
        out_valid <= 1'b0;
      end
      if (issue && item) begin
        p_valid <= 1'b1;
      end else if (p_moves) begin
        p_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx_fire) begin
            if (rx.rx_byte == CH_DOLLAR) begin
              capturing       <= 1'b1;
              field_number    <= '0;
              validity_length <= '0;
              validity_is_a   <= 1'b0;
              for (int i = 0; i < KEPT_FIELDS; i++) begin
                field_lengths[i] <= '0;
              end
            end else if (capturing) begin
              if (rx.rx_byte == CH_STAR) begin
                capturing <= 1'b0;
                state     <= S_EMIT;
              end else if ((rx.rx_byte == CH_COMMA) && (field_number < FN_LAST)) begin
                field_number <= field_number + FN_W'(1);
              end else if (field_number == FN_VALIDITY) begin
                if (validity_length == '0) begin
                  validity_is_a <= (rx.rx_byte == CH_A);
                end
                if (validity_length != '1) begin
                  validity_length <= validity_length + VLEN_W'(1);
                end
              end else if (ram_we) begin
                field_lengths[parse_sel.slot] <= len_cur + LEN_W'(1);
              end
            end
          end
        end
        S_EMIT: begin
          if (issue && run_done) begin
            state           <= S_IDLE;
            field_number    <= '0;
            validity_length <= '0;
            validity_is_a   <= 1'b0;
            for (int i = 0; i < KEPT_FIELDS; i++) begin
              field_lengths[i] <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_no_write_in_run, clk, rst, ram_we |-> (state == S_IDLE), "RAM written during a run")
  `ASSERT_CLK(a_run_starts, clk, rst, (rx_fire && capturing && (rx.rx_byte == CH_STAR)) |=> ((state == S_EMIT) && (cur_pos == '0) && (cur_slot == '0)), "Run did not start after end of sentence")
  `ASSERT_CLK(a_run_ends, clk, rst, (issue && item && item_last) |=> ((state == S_IDLE) && p_valid && p_last), "Last character fetched but run not closed")

endmodule

// ===== rtl/nrmc_field_ram.sv =====
// Single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps

module nrmc_field_ram #(
  parameter int DEPTH = 60,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== dv/nmea_rmc_field_extractor_checker.sv =====
// Checker that predicts the output runs of the RMC field extractor and compares them.
`timescale 1ns / 1ps

module nmea_rmc_field_extractor_checker
  import nrmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  nrmc_in_if         rx,
  nrmc_out_if        tx,
  output int         fail_count,
  output int         pending,
  output int         fix_runs,
  output int         nofix_runs
);

  typedef struct packed {
    byte_t ch;
    logic  fix;
    logic  last;
  } out_char_t;

  localparam byte_t NO_FIX_TEXT [INVALID_LEN] =
    '{8'h49, 8'h6E, 8'h76, 8'h61, 8'h6C, 8'h69, 8'h64, 8'h0A};

  out_char_t         expected_chars[$];
  logic              in_sentence;
  logic [FN_W-1:0]   field_idx;
  byte_t             field_bytes [KEPT_FIELDS][MAX_FIELD_LEN];
  int                field_len [KEPT_FIELDS];
  logic [VLEN_W-1:0] validity_len;
  logic              validity_a;

  function automatic int kept_slot(input logic [FN_W-1:0] fn);
    case (fn)
      4'd1:    return 0;
      4'd3:    return 1;
      4'd4:    return 2;
      4'd5:    return 3;
      4'd6:    return 4;
      default: return -1;
    endcase
  endfunction

  task automatic restart_capture();
    field_idx = '0;
    for (int s = 0; s < KEPT_FIELDS; s++) field_len[s] = 0;
    validity_len = '0;
    validity_a = 1'b0;
  endtask

  task automatic push_char(input byte_t ch, input logic fix);
    out_char_t c;
    c.ch = ch;
    c.fix = fix;
    c.last = 1'b0;
    expected_chars.push_back(c);
  endtask

  task automatic absorb_byte(input byte_t b);
    out_char_t c;
    int        s;
    if (b == CH_DOLLAR) begin
      in_sentence = 1'b1;
      restart_capture();
    end else if (in_sentence) begin
      if (b == CH_STAR) begin
        in_sentence = 1'b0;
        if (validity_a && validity_len == 1) begin
          for (int k = 0; k < KEPT_FIELDS; k++) begin
            if (k > 0) push_char(CH_SEMI, 1'b1);
            for (int i = 0; i < field_len[k]; i++) push_char(field_bytes[k][i], 1'b1);
          end
          fix_runs++;
        end else begin
          for (int i = 0; i < INVALID_LEN; i++) push_char(NO_FIX_TEXT[i], 1'b0);
          nofix_runs++;
        end
        c = expected_chars.pop_back();
        c.last = 1'b1;
        expected_chars.push_back(c);
        restart_capture();
      end else if (b == CH_COMMA && field_idx < FN_LAST) begin
        field_idx = field_idx + 1'b1;
      end else if (field_idx == FN_VALIDITY) begin
        if (validity_len == 0) validity_a = (b == CH_A);
        if (validity_len < 15) validity_len = validity_len + 1'b1;
      end else begin
        s = kept_slot(field_idx);
        if (s >= 0 && field_len[s] < MAX_FIELD_LEN) begin
          field_bytes[s][field_len[s]] = b;
          field_len[s]++;
        end
      end
    end
  endtask

  task automatic check_char();
    out_char_t c;
    if (expected_chars.size() == 0) begin
      $error("Unexpected output transaction: out_byte %h", tx.out_byte);
      fail_count++;
    end else begin
      c = expected_chars.pop_front();
      if (tx.out_byte !== c.ch) begin
        $error("out_byte mismatch: expected %h, actual %h", c.ch, tx.out_byte);
        fail_count++;
      end
      if (tx.fix_valid !== c.fix) begin
        $error("fix_valid mismatch: expected %b, actual %b", c.fix, tx.fix_valid);
        fail_count++;
      end
      if (tx.last_of_run !== c.last) begin
        $error("last_of_run mismatch: expected %b, actual %b", c.last, tx.last_of_run);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_sentence = 1'b0;
      restart_capture();
      expected_chars.delete();
    end else begin
      if (rx.valid && rx.ready) absorb_byte(rx.rx_byte);
      if (tx.valid && tx.ready) check_char();
    end
    pending = expected_chars.size();
  end

endmodule

// ===== dv/nmea_rmc_field_extractor_tb.sv =====
// Testbench top of the RMC field extractor: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module nmea_rmc_field_extractor_tb;
  import nrmc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 4;
  localparam int PHASE_BYTES = 26;
  localparam int IDLE_PCT [PHASES] = '{0, 56, 0, 22};
  localparam int STALL_PCT [PHASES] = '{0, 0, 56, 22};

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   byte_count;
  int   cycles;
  int   fail_count;
  int   pending;
  int   fix_runs;
  int   nofix_runs;

  nrmc_in_if  rx_ch ();
  nrmc_out_if tx_ch ();

  nmea_rmc_field_extractor u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .tx  (tx_ch)
  );

  nmea_rmc_field_extractor_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_ch),
    .tx         (tx_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .fix_runs   (fix_runs),
    .nofix_runs (nofix_runs)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    tx_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      tx_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic byte_t plain_char();
    byte_t b;
    do b = byte_t'($urandom_range(255));
    while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
    return b;
  endfunction

  task automatic send(input byte_t b);
    while ($urandom_range(99) < idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
    byte_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send(byte_t'(s[i]));
  endtask

  task automatic send_sentence();
    int n_fields;
    int flen;
    send(CH_DOLLAR);
    repeat ($urandom_range(3)) send(plain_char());
    n_fields = ($urandom_range(9) == 0) ? $urandom_range(12, 15) : $urandom_range(1, 8);
    for (int f = 1; f <= n_fields; f++) begin
      send(CH_COMMA);
      if (f == 2) begin
        case ($urandom_range(9))
          7: send_text("V");
          8: ;
          9: begin
            send(CH_A);
            send(plain_char());
          end
          default: send(CH_A);
        endcase
      end else begin
        flen = ($urandom_range(7) == 0) ? $urandom_range(10, 15) : $urandom_range(5);
        repeat (flen) send(plain_char());
      end
    end
    if ($urandom_range(99) < 88) send(CH_STAR);
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  initial begin
    int target;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_text("Q*");
    send_text("$5$,A*");
    send_text("$,,AB*");
    send_text("$,");
    send(8'h00);
    send(8'hFF);
    repeat (11) send(plain_char());
    send_text(",A,,,,,,,,,,,,*");
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_pct = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      target = byte_count + PHASE_BYTES;
      while (byte_count < target) begin
        if ($urandom_range(5) == 0) begin
          repeat ($urandom_range(1, 4)) send(byte_t'($urandom_range(255)));
        end else begin
          send_sentence();
        end
      end
      drain();
    end

    rx_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("Sent %0d bytes through four idle and stall phases.", byte_count);
    $display("Checked %0d position runs and %0d Invalid runs.", fix_runs, nofix_runs);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== nmea_rmc_field_extractor.f =====
+incdir+rtl
rtl/nrmc_pkg.sv
rtl/nrmc_in_if.sv
rtl/nrmc_out_if.sv
rtl/nrmc_field_ram.sv
rtl/nmea_rmc_field_extractor.sv
dv/nmea_rmc_field_extractor_checker.sv
dv/nmea_rmc_field_extractor_tb.sv
